@@ hdl/rau_pkg.sv @@
// Package with the shared types and constants of the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 31;
    localparam int OP_W      = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_EQ  = 4'd4,
        OP_NE  = 4'd5,
        OP_GE  = 4'd6,
        OP_LE  = 4'd7,
        OP_GT  = 4'd8,
        OP_LT  = 4'd9
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_A,
        S_WAIT_A,
        S_LOAD_B,
        S_WAIT_B,
        S_MUL,
        S_SETUP,
        S_WAIT_R,
        S_DONE
    } t_top_state;

    typedef enum logic [2:0] {
        RD_IDLE,
        RD_TWOS,
        RD_LOOP,
        RD_DIVN,
        RD_DIVD,
        RD_DONE
    } t_red_state;

endpackage
`default_nettype wire

@@ hdl/rau_if.sv @@
// Request and response channel interfaces of the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
interface rau_req_if #(
    parameter int OPERAND_WIDTH = 16
);
    logic                            valid;
    logic                            ready;
    logic [rau_pkg::OP_W-1:0]        operation;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;

    modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rau_pkg::NUM_OUT_W-1:0] result_num;
    logic [rau_pkg::DEN_OUT_W-1:0]        result_den;
    logic                                 compare_true;

    modport source (output valid, result_num, result_den, compare_true, input ready);
    modport sink   (input valid, result_num, result_den, compare_true, output ready);
endinterface
`default_nettype wire

@@ hdl/rau_reduce.sv @@
// Fraction reducer: binary GCD followed by two shift-subtract divisions.
`timescale 1ns / 1ps
`default_nettype none
module rau_reduce #(
    parameter int PW = 33
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_neg,
    input  wire logic [PW-1:0] i_num,
    input  wire logic [PW-1:0] i_den,
    output logic               o_done,
    output logic               o_neg,
    output logic [PW-1:0]      o_num,
    output logic [PW-1:0]      o_den
);
    localparam int KW = $clog2(PW + 1);
    localparam int CW = $clog2(PW);

    rau_pkg::t_red_state r_state, n_state;
    logic [PW-1:0] r_u, n_u, r_v, n_v, r_g, n_g;
    logic [PW-1:0] r_num, n_num, r_den, n_den;
    logic [PW-1:0] r_q, n_q, r_rem, n_rem;
    logic [KW-1:0] r_k, n_k;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_neg, n_neg;
    logic [PW:0]   trial, diff;
    logic [PW-1:0] q_step;
    logic          ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::RD_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_u   <= n_u;
        r_v   <= n_v;
        r_g   <= n_g;
        r_num <= n_num;
        r_den <= n_den;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_k   <= n_k;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
    end

    always_comb begin
        n_state = r_state;
        n_u     = r_u;
        n_v     = r_v;
        n_g     = r_g;
        n_num   = r_num;
        n_den   = r_den;
        n_q     = r_q;
        n_rem   = r_rem;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        // One restoring division step: shift in the next dividend bit, try to subtract.
        trial   = {r_rem, r_q[PW-1]};
        diff    = trial - {1'b0, r_g};
        ge      = !diff[PW];
        q_step  = {r_q[PW-2:0], ge};
        unique case (r_state)
            rau_pkg::RD_IDLE: begin
                if (i_start) begin
                    n_neg = i_neg;
                    n_num = i_num;
                    n_den = i_den;
                    n_u   = i_num;
                    n_v   = i_den;
                    n_k   = '0;
                    if (i_num == '0) begin
                        n_neg   = 1'b0;
                        n_den   = PW'(1);
                        n_state = rau_pkg::RD_DONE;
                    end else begin
                        n_state = rau_pkg::RD_TWOS;
                    end
                end
            end
            rau_pkg::RD_TWOS: begin
                if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + KW'(1);
                end else begin
                    n_state = rau_pkg::RD_LOOP;
                end
            end
            rau_pkg::RD_LOOP: begin
                priority if (r_u == '0) begin
                    n_g     = r_v << r_k;
                    n_q     = r_num;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = rau_pkg::RD_DIVN;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (r_u >= r_v) begin
                    n_u = (r_u - r_v) >> 1;
                end else begin
                    n_v = (r_v - r_u) >> 1;
                end
            end
            rau_pkg::RD_DIVN, rau_pkg::RD_DIVD: begin
                n_rem = ge ? diff[PW-1:0] : trial[PW-1:0];
                n_q   = q_step;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(PW - 1)) begin
                    n_cnt = '0;
                    n_rem = '0;
                    if (r_state == rau_pkg::RD_DIVN) begin
                        n_num   = q_step;
                        n_q     = r_den;
                        n_state = rau_pkg::RD_DIVD;
                    end else begin
                        n_den   = q_step;
                        n_state = rau_pkg::RD_DONE;
                    end
                end
            end
            rau_pkg::RD_DONE: begin
                n_state = rau_pkg::RD_IDLE;
            end
            default: begin
                n_state = rau_pkg::RD_IDLE;
            end
        endcase
    end

    assign o_done = (r_state == rau_pkg::RD_DONE);
    assign o_neg  = r_neg;
    assign o_num  = r_num;
    assign o_den  = r_den;
endmodule
`default_nettype wire

@@ hdl/rational_arith_unit_top.sv @@
// Top level of the rational arithmetic unit: sequencer, shared multiplier and output register.
// Usage:
// Requests arrive on i_req (valid/ready); a request carries an operation code and two
// fractions a_num/a_den and b_num/b_den in two's complement. Responses leave on o_rsp
// (valid/ready) with the reduced numerator, the positive reduced denominator and a
// comparison flag. Exactly one response is produced for every accepted request.
// Each request runs through one shared fraction reducer three times (operand a, operand b
// and the result) and through one shared multiplier for five products.
// A reduction runs the binary GCD loop and two shift-subtract divisions at width PW,
// where PW = 2*OPERAND_WIDTH+1; a zero numerator skips the GCD loop and both divisions.
// Comparisons and unused operation codes skip the third reduction.
// The block takes one request at a time; i_req.ready is high only while the sequencer is idle.
// A finished response sits in the output register; the next request can be accepted and
// worked on while that response still waits, and the sequencer holds its result until
// the output register is free.
// Reset (synchronous, active low) returns the sequencer and reducer to idle and
// empties the output register; no memory needs clearing.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_unit_top #(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rau_req_if.sink     i_req,
    rau_rsp_if.source   o_rsp
);
    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W + 1;
    localparam int XW = (PW + 1 > rau_pkg::NUM_OUT_W) ? PW + 1 : rau_pkg::NUM_OUT_W;

    rau_pkg::t_top_state r_state, n_state;

    // Captured request.
    logic [rau_pkg::OP_W-1:0] r_op;
    logic [W-1:0] r_in_an, r_in_ad, r_in_bn, r_in_bd;

    // Normalized operands.
    logic         r_aneg, r_bneg;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;

    // Products from the shared multiplier.
    logic [PW-1:0] r_t1, r_t2, r_dd, r_nn, r_db;
    logic [2:0]    r_mcnt;

    // Result before output formatting.
    logic          r_res_neg, r_flag;
    logic [PW-1:0] r_res_num, r_res_den;

    // Output register.
    logic                                 r_o_valid;
    logic signed [rau_pkg::NUM_OUT_W-1:0] r_o_num;
    logic [rau_pkg::DEN_OUT_W-1:0]        r_o_den;
    logic                                 r_o_flag;

    // Reducer connection.
    logic          red_start, red_neg, red_done, red_oneg;
    logic [PW-1:0] red_num, red_den, red_onum, red_oden;

    logic [W-1:0]    mul_x, mul_y;
    logic [2*W-1:0]  mul_p;
    logic [W-1:0]    ld_num, ld_den_raw, nm, dm;
    logic            nn_s, dn_s;
    logic            s1, s2, a_eff, b_eff, c_eq, c_gt, c_lt, flag_v;
    logic [PW-1:0]   sum_v, d12, d21;
    logic            out_free;
    logic [XW-1:0]   ext_num, sgn_num, ext_den;

    rau_reduce #(.PW(PW)) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (red_start),
        .i_neg   (red_neg),
        .i_num   (red_num),
        .i_den   (red_den),
        .o_done  (red_done),
        .o_neg   (red_oneg),
        .o_num   (red_onum),
        .o_den   (red_oden)
    );

    // Magnitude and sign of the operand being loaded; a zero denominator becomes one.
    always_comb begin
        ld_num     = (r_state == rau_pkg::S_LOAD_A) ? r_in_an : r_in_bn;
        ld_den_raw = (r_state == rau_pkg::S_LOAD_A) ? r_in_ad : r_in_bd;
        nn_s       = ld_num[W-1];
        dn_s       = ld_den_raw[W-1];
        nm         = nn_s ? W'(-ld_num) : ld_num;
        dm         = dn_s ? W'(-ld_den_raw) : ld_den_raw;
        if (dm == '0) begin
            dm   = W'(1);
            dn_s = 1'b0;
        end
    end

    // The multiplier serves one product per cycle, selected by the step counter.
    always_comb begin
        unique case (r_mcnt)
            3'd0:    begin mul_x = r_an; mul_y = r_bd; end
            3'd1:    begin mul_x = r_bn; mul_y = r_ad; end
            3'd2:    begin mul_x = r_ad; mul_y = r_bd; end
            3'd3:    begin mul_x = r_an; mul_y = r_bn; end
            default: begin mul_x = r_ad; mul_y = r_bn; end
        endcase
        mul_p = mul_x * mul_y;
    end

    // Sign handling for add and subtract, and the comparison of a.num*b.den to b.num*a.den.
    always_comb begin
        s1     = r_aneg;
        s2     = (r_op == rau_pkg::OP_SUB) ? !r_bneg : r_bneg;
        sum_v  = r_t1 + r_t2;
        d12    = r_t1 - r_t2;
        d21    = r_t2 - r_t1;
        a_eff  = r_aneg && (r_t1 != '0);
        b_eff  = r_bneg && (r_t2 != '0);
        c_eq   = (a_eff == b_eff) && (r_t1 == r_t2);
        if (a_eff != b_eff) begin
            c_gt = !a_eff;
        end else if (!a_eff) begin
            c_gt = r_t1 > r_t2;
        end else begin
            c_gt = r_t1 < r_t2;
        end
        c_lt   = !c_eq && !c_gt;
        unique case (r_op)
            rau_pkg::OP_EQ: flag_v = c_eq;
            rau_pkg::OP_NE: flag_v = !c_eq;
            rau_pkg::OP_GE: flag_v = !c_lt;
            rau_pkg::OP_LE: flag_v = !c_gt;
            rau_pkg::OP_GT: flag_v = c_gt;
            rau_pkg::OP_LT: flag_v = c_lt;
            default:        flag_v = 1'b0;
        endcase
    end

    assign out_free = !r_o_valid || o_rsp.ready;

    // Sequencer: next state and reducer requests.
    always_comb begin
        n_state   = r_state;
        red_start = 1'b0;
        red_neg   = nn_s != dn_s;
        red_num   = PW'(nm);
        red_den   = PW'(dm);
        unique case (r_state)
            rau_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state = rau_pkg::S_LOAD_A;
                end
            end
            rau_pkg::S_LOAD_A: begin
                red_start = 1'b1;
                n_state   = rau_pkg::S_WAIT_A;
            end
            rau_pkg::S_WAIT_A: begin
                if (red_done) begin
                    n_state = rau_pkg::S_LOAD_B;
                end
            end
            rau_pkg::S_LOAD_B: begin
                red_start = 1'b1;
                n_state   = rau_pkg::S_WAIT_B;
            end
            rau_pkg::S_WAIT_B: begin
                if (red_done) begin
                    n_state = rau_pkg::S_MUL;
                end
            end
            rau_pkg::S_MUL: begin
                if (r_mcnt == 3'd4) begin
                    n_state = rau_pkg::S_SETUP;
                end
            end
            rau_pkg::S_SETUP: begin
                n_state = rau_pkg::S_WAIT_R;
                red_den = r_dd;
                priority case (r_op)
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                        red_start = 1'b1;
                        priority if (s1 == s2) begin
                            red_neg = s1;
                            red_num = sum_v;
                        end else if (r_t1 >= r_t2) begin
                            red_neg = s1;
                            red_num = d12;
                        end else begin
                            red_neg = s2;
                            red_num = d21;
                        end
                    end
                    rau_pkg::OP_MUL: begin
                        red_start = 1'b1;
                        red_neg   = r_aneg != r_bneg;
                        red_num   = r_nn;
                    end
                    rau_pkg::OP_DIV: begin
                        red_start = 1'b1;
                        red_num   = r_t1;
                        if (r_db == '0) begin
                            red_neg = r_aneg;
                            red_den = PW'(1);
                        end else begin
                            red_neg = r_aneg != r_bneg;
                            red_den = r_db;
                        end
                    end
                    default: begin
                        n_state = rau_pkg::S_DONE;
                    end
                endcase
            end
            rau_pkg::S_WAIT_R: begin
                if (red_done) begin
                    n_state = rau_pkg::S_DONE;
                end
            end
            rau_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = rau_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rau_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == rau_pkg::S_IDLE && i_req.valid) begin
            r_op    <= i_req.operation;
            r_in_an <= i_req.a_num;
            r_in_ad <= i_req.a_den;
            r_in_bn <= i_req.b_num;
            r_in_bd <= i_req.b_den;
        end
        if (r_state == rau_pkg::S_WAIT_A && red_done) begin
            r_aneg <= red_oneg;
            r_an   <= red_onum[W-1:0];
            r_ad   <= red_oden[W-1:0];
        end
        if (r_state == rau_pkg::S_WAIT_B && red_done) begin
            r_bneg <= red_oneg;
            r_bn   <= red_onum[W-1:0];
            r_bd   <= red_oden[W-1:0];
            r_mcnt <= '0;
        end
        if (r_state == rau_pkg::S_MUL) begin
            r_mcnt <= r_mcnt + 3'd1;
            unique case (r_mcnt)
                3'd0:    r_t1 <= PW'(mul_p);
                3'd1:    r_t2 <= PW'(mul_p);
                3'd2:    r_dd <= PW'(mul_p);
                3'd3:    r_nn <= PW'(mul_p);
                default: r_db <= PW'(mul_p);
            endcase
        end
        if (r_state == rau_pkg::S_SETUP) begin
            // Comparisons and unused codes give 0/1 here; arithmetic overwrites it later.
            r_res_neg <= 1'b0;
            r_res_num <= '0;
            r_res_den <= PW'(1);
            r_flag    <= flag_v;
        end
        if (r_state == rau_pkg::S_WAIT_R && red_done) begin
            r_res_neg <= red_oneg;
            r_res_num <= red_onum;
            r_res_den <= red_oden;
        end
    end

    // Output formatting: two's complement numerator cut to the field widths.
    always_comb begin
        ext_num = XW'(r_res_num);
        sgn_num = r_res_neg ? -ext_num : ext_num;
        ext_den = XW'(r_res_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == rau_pkg::S_DONE && out_free) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
        if (r_state == rau_pkg::S_DONE && out_free) begin
            r_o_num  <= sgn_num[rau_pkg::NUM_OUT_W-1:0];
            r_o_den  <= ext_den[rau_pkg::DEN_OUT_W-1:0];
            r_o_flag <= r_flag;
        end
    end

    assign i_req.ready        = (r_state == rau_pkg::S_IDLE);
    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.result_num   = r_o_num;
    assign o_rsp.result_den   = r_o_den;
    assign o_rsp.compare_true = r_o_flag;
endmodule
`default_nettype wire

@@ hdl/rau_checker.sv @@
// Port-level assertions for the rational arithmetic unit and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rau_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_req_valid,
    input wire logic                          i_req_ready,
    input wire logic                          i_rsp_valid,
    input wire logic                          i_rsp_ready,
    input wire logic [rau_pkg::NUM_OUT_W-1:0] i_rsp_num,
    input wire logic [rau_pkg::DEN_OUT_W-1:0] i_rsp_den,
    input wire logic                          i_rsp_flag
);
    // A stalled response stays offered.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // The unit works on one request at a time.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while busy");

    // A true comparison carries the fraction 0/1.
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_flag |-> i_rsp_num == '0 && i_rsp_den == rau_pkg::DEN_OUT_W'(1))
        else $error("comparison result not 0/1");

    // A zero numerator is always reduced to denominator one.
    a_zero_den_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_num == '0 |-> i_rsp_den == rau_pkg::DEN_OUT_W'(1))
        else $error("zero result not over one");
endmodule

bind rational_arith_unit_top rau_checker u_rau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_num   (o_rsp.result_num),
    .i_rsp_den   (o_rsp.result_den),
    .i_rsp_flag  (o_rsp.compare_true)
);
`default_nettype wire

@@ tb/tb_rational_arith_unit_top.sv @@
// Self-checking testbench for the rational arithmetic unit: directed and random requests.
`timescale 1ns / 1ps
`default_nettype none
module tb_rational_arith_unit_top;

    typedef struct packed {
        logic signed [rau_pkg::NUM_OUT_W-1:0] num;
        logic [rau_pkg::DEN_OUT_W-1:0]        den;
        logic                                 flag;
    } t_fraction_result;

    // Exact sign-magnitude model of the unit. Operands are normalized, combined by
    // cross-multiplication and reduced again; comparisons only produce the flag.
    class rational_scoreboard;
        t_fraction_result pending[$];
        int               mismatches;
        int               checked;

        static function longint unsigned gcd64(longint unsigned x, longint unsigned y);
            longint unsigned t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        // Reduces |num|/den in place; a zero numerator becomes a positive 0/1.
        static function void shrink(ref bit neg, ref longint unsigned num,
                                    ref longint unsigned den);
            longint unsigned g;
            if (num == 0) begin
                neg = 0;
                den = 1;
                return;
            end
            g = gcd64(num, den);
            num = num / g;
            den = den / g;
        endfunction

        static function void load(logic signed [15:0] rn, logic signed [15:0] rd,
                                  output bit neg, output longint unsigned num,
                                  output longint unsigned den);
            bit nn;
            bit dn;
            longint signed sn;
            longint signed sd;
            sn = rn;
            sd = rd;
            nn = sn < 0;
            dn = sd < 0;
            num = nn ? -sn : sn;
            den = dn ? -sd : sd;
            if (den == 0) begin
                den = 1;
                dn = 0;
            end
            neg = nn != dn;
            shrink(neg, num, den);
        endfunction

        function void note_request(rau_pkg::t_op op, logic signed [15:0] an,
                                   logic signed [15:0] ad, logic signed [15:0] bn,
                                   logic signed [15:0] bd);
            bit              a_neg, b_neg, r_neg, s2;
            longint unsigned a_n, a_d, b_n, b_d, t1, t2, r_n, r_d;
            int              order;
            t_fraction_result res;
            load(an, ad, a_neg, a_n, a_d);
            load(bn, bd, b_neg, b_n, b_d);
            t1 = a_n * b_d;
            t2 = b_n * a_d;
            r_neg = 0;
            r_n = 0;
            r_d = 1;
            res.flag = 0;
            case (op)
                rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                    s2 = (op == rau_pkg::OP_SUB) ? !b_neg : b_neg;
                    r_d = a_d * b_d;
                    if (a_neg == s2) begin
                        r_neg = a_neg;
                        r_n = t1 + t2;
                    end else if (t1 >= t2) begin
                        r_neg = a_neg;
                        r_n = t1 - t2;
                    end else begin
                        r_neg = s2;
                        r_n = t2 - t1;
                    end
                end
                rau_pkg::OP_MUL: begin
                    r_neg = a_neg != b_neg;
                    r_n = a_n * b_n;
                    r_d = a_d * b_d;
                end
                rau_pkg::OP_DIV: begin
                    r_n = t1;
                    r_d = a_d * b_n;
                    // A zero divisor falls back to a denominator of one.
                    if (r_d == 0) begin
                        r_neg = a_neg;
                        r_d = 1;
                    end else begin
                        r_neg = a_neg != b_neg;
                    end
                end
                rau_pkg::OP_EQ, rau_pkg::OP_NE, rau_pkg::OP_GE,
                rau_pkg::OP_LE, rau_pkg::OP_GT, rau_pkg::OP_LT: begin
                    if (t1 == 0) a_neg = 0;
                    if (t2 == 0) b_neg = 0;
                    if (a_neg != b_neg) order = a_neg ? -1 : 1;
                    else if (t1 == t2) order = 0;
                    else if (!a_neg) order = (t1 > t2) ? 1 : -1;
                    else order = (t1 > t2) ? -1 : 1;
                    case (op)
                        rau_pkg::OP_EQ: res.flag = order == 0;
                        rau_pkg::OP_NE: res.flag = order != 0;
                        rau_pkg::OP_GE: res.flag = order >= 0;
                        rau_pkg::OP_LE: res.flag = order <= 0;
                        rau_pkg::OP_GT: res.flag = order > 0;
                        default: res.flag = order < 0;
                    endcase
                end
                default: ;
            endcase
            shrink(r_neg, r_n, r_d);
            res.num = rau_pkg::NUM_OUT_W'(r_neg ? -r_n : r_n);
            res.den = rau_pkg::DEN_OUT_W'(r_d);
            pending.push_back(res);
        endfunction

        function void check_result(t_fraction_result got);
            t_fraction_result want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result num=%0d den=%0d flag=%0b",
                             got.num, got.den, got.flag);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: want %0d/%0d flag %0b, got %0d/%0d flag %0b",
                             want.num, want.den, want.flag, got.num, got.den, got.flag);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rau_req_if #(.OPERAND_WIDTH(16)) req_ch ();
    rau_rsp_if                       rsp_ch ();

    rational_arith_unit_top #(.OPERAND_WIDTH(16)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    rational_scoreboard fractions;
    int  requests_sent;
    bit  idle_free;     // set for the last part of the run, where nobody idles
    int  hold_cycles;   // long receiver hold-off, counted down by the response side

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // The run is far shorter than this even with every request at its slowest.
    initial begin
        #8000000;
        $display("tb_rational_arith_unit_top: done, errors");
        $finish;
    end

    // Picks an operand value that favors the edges of the 16-bit range.
    function automatic logic signed [15:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sd0;
            3: return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
            4: return 16'($signed($urandom_range(0, 24)) - 12);
            default: return 16'($urandom);
        endcase
    endfunction

    // Offers one request and holds it until the block takes it. The request stays
    // offered afterwards; the next call replaces it or idles, wait_drained withdraws it.
    task automatic send_request(rau_pkg::t_op op, logic signed [15:0] an,
                                logic signed [15:0] ad, logic signed [15:0] bn,
                                logic signed [15:0] bd);
        int gap;
        if (!idle_free && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 0;
            for (gap = $urandom_range(1, 11); gap > 0; gap--) @(negedge i_clk);
        end
        req_ch.valid     <= 1;
        req_ch.operation <= op;
        req_ch.a_num     <= an;
        req_ch.a_den     <= ad;
        req_ch.b_num     <= bn;
        req_ch.b_den     <= bd;
        do @(posedge i_clk); while (!req_ch.ready);
        fractions.note_request(op, an, ad, bn, bd);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random(int count);
        int n;
        for (n = 0; n < count; n++)
            send_request(rau_pkg::t_op'($urandom_range(0, 15)), pick_operand(),
                         pick_operand(), pick_operand(), pick_operand());
    endtask

    task automatic wait_drained();
        req_ch.valid <= 0;
        do @(negedge i_clk); while (fractions.pending.size() != 0);
    endtask

    // Response side: sampled on the rising edge, ready changed on the falling one.
    initial begin
        int stall;
        rsp_ch.ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                rsp_ch.ready <= 0;
                while (hold_cycles > 0) begin
                    @(negedge i_clk);
                    hold_cycles--;
                end
            end else if (!idle_free && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 0;
                for (stall = $urandom_range(1, 11); stall > 0; stall--) @(negedge i_clk);
            end
            rsp_ch.ready <= 1;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            fractions.check_result('{rsp_ch.result_num, rsp_ch.result_den,
                                     rsp_ch.compare_true});

    initial begin
        fractions     = new();
        requests_sent = 0;
        idle_free     = 0;
        hold_cycles   = 0;
        i_rst_n       = 0;
        req_ch.valid     = 0;
        req_ch.operation = rau_pkg::OP_ADD;
        req_ch.a_num     = 0;
        req_ch.a_den     = 0;
        req_ch.b_num     = 0;
        req_ch.b_den     = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: every operation on range extremes, zero denominators, zero divisor.
        for (int op = 0; op < 10; op++)
            send_request(rau_pkg::t_op'(op), 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_request(rau_pkg::OP_ADD, 16'sh8000, 16'sd0, 16'sh8000, 16'sd0);
        send_request(rau_pkg::OP_SUB, 16'sh7fff, 16'sd1, 16'sh8000, 16'sh7fff);
        send_request(rau_pkg::OP_MUL, 16'sh8000, 16'sh8001, 16'sh8000, 16'sh8001);
        send_request(rau_pkg::OP_DIV, 16'sd5, -16'sd3, 16'sd0, 16'sd7);
        send_request(rau_pkg::OP_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_request(rau_pkg::OP_EQ, 16'sd2, 16'sd4, -16'sd3, -16'sd6);
        send_request(rau_pkg::OP_LT, -16'sd1, 16'sd2, 16'sd0, -16'sd5);
        send_request(rau_pkg::OP_GE, 16'sd0, -16'sd9, 16'sd0, 16'sd3);
        send_request(rau_pkg::OP_DIV, -16'sd6, 16'sd4, 16'sd3, -16'sd2);
        send_request(rau_pkg::t_op'(4'd10), 16'sd1, 16'sd1, 16'sd1, 16'sd1);
        send_request(rau_pkg::t_op'(4'd15), -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_request(rau_pkg::OP_ADD, 16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555);

        // Hold the receiver off long enough that the block fills and stalls its input.
        hold_cycles = 3000;
        send_random(6);
        // Sender pauses until all earlier requests have been answered.
        wait_drained();
        send_random(680);
        idle_free = 1;
        send_random(100);

        wait_drained();
        repeat (500) @(negedge i_clk);
        $display("covered %0d requests and %0d responses: all ten operations,",
                 requests_sent, fractions.checked);
        $display("unused codes, zero denominators and divisors, and long output stalls");
        if (fractions.mismatches == 0 && fractions.pending.size() == 0)
            $display("tb_rational_arith_unit_top: done, clean");
        else
            $display("tb_rational_arith_unit_top: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
